[src/swmm_pkg.sv]
// Shared types and constants for the sliding window min/max/average core.
// No dependencies.
package swmm_pkg;

    localparam int unsigned SampleW = 16;
    localparam int unsigned HourW   = 5;
    localparam int unsigned MinuteW = 6;
    localparam int unsigned OffsetW = 8;
    localparam int unsigned CountW  = 9;

    localparam logic [SampleW-1:0] SampleMin = '0;
    localparam logic [SampleW-1:0] SampleMax = '1;

    // Operation codes
    localparam logic OpPush = 1'b0;
    localparam logic OpRead = 1'b1;

    // One stored sensor record (59 bits)
    typedef struct packed {
        logic [SampleW-1:0] co2;
        logic [SampleW-1:0] snd;
        logic [SampleW-1:0] peak;
        logic [HourW-1:0]   hr;
        logic [MinuteW-1:0] mn;
    } rec_t;

    localparam int unsigned RecW = $bits(rec_t);

endpackage

[src/swmm_ram.sv]
// Generic single-port synchronous RAM, registered read, write-first not guaranteed.
// No dependencies.
module swmm_ram #(
    parameter int unsigned WIDTH = 59,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[src/swmm_div.sv]
// Restoring divider, one quotient bit per cycle.
// No dependencies; divisor must be non-zero when started.
module swmm_div #(
    parameter int unsigned DW = 25,
    parameter int unsigned VW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int unsigned NW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quot_reg, quot_next;
    logic [VW-1:0] dvs_reg;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   shifted;
    logic [VW:0]   diff;

    // one restoring step
    always_comb
    begin
        shifted   = {rem_reg, quot_reg[DW-1]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            cnt_next  = NW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[VW])
            begin
                rem_next  = diff[VW-1:0];
                quot_next = {quot_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[VW-1:0];
                quot_next = {quot_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[src/sliding_window_min_max_average_core.sv]
// Top level of the sliding window min/max/average core.
// Depends on swmm_pkg, swmm_ram and swmm_div.
//
// Usage: one input channel (in_valid/in_ready) carries push or read
// transactions; one output channel (out_valid/out_ready) returns one result
// transaction per input: window CO2 max/min, peak sound max, sound min,
// truncated average sound and record count, plus the record fields for reads.
// One item is handled at a time; in_ready is high only while the sequencer
// is idle. A finished result sits in the output register, so the next item
// can be taken while the receiver stalls.
// Per item: a read or push passes through the sequencer states and then the
// divider, which yields one quotient bit per cycle over a TW-bit dividend
// (TW = 16 + clog2(WINDOW_DEPTH+1), 25 at depth 256); a push
// that evicts a current extreme adds a rescan of every window entry
// through the single RAM port. An empty window skips the divider.
// Reset clears pointer, count, statistics and out_valid (not the output data); the
// record RAM is not cleared (only written entries are ever read).
// If out_ready is low, the finished result waits in the sequencer until the
// output register frees.
module sliding_window_min_max_average_core #(
    parameter int unsigned WINDOW_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [15:0] co2_level,
    input  logic [15:0] sound_level,
    input  logic [15:0] peak_sound,
    input  logic [4:0]  hour_stamp,
    input  logic [5:0]  minute_stamp,
    input  logic [7:0]  read_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] co2_max,
    output logic [15:0] co2_min,
    output logic [15:0] peak_sound_max,
    output logic [15:0] sound_min,
    output logic [15:0] sound_average,
    output logic [8:0]  record_count,
    output logic        rec_valid,
    output logic [15:0] rec_co2,
    output logic [15:0] rec_sound,
    output logic [15:0] rec_peak,
    output logic [4:0]  rec_hour,
    output logic [5:0]  rec_minute
);

    import swmm_pkg::*;

    localparam int unsigned AW   = $clog2(WINDOW_DEPTH);
    localparam int unsigned CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned TW   = SampleW + CW;
    localparam int unsigned XW   = (CW > CountW) ? CW : CountW;
    localparam int unsigned OW   = (CW > OffsetW) ? CW : OffsetW;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PUSH = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RDW  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DIVW = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic               wrapped_reg, wrapped_next;
    logic [SampleW-1:0] co2_hi_reg, co2_hi_next;
    logic [SampleW-1:0] co2_lo_reg, co2_lo_next;
    logic [SampleW-1:0] pk_hi_reg, pk_hi_next;
    logic [SampleW-1:0] snd_lo_reg, snd_lo_next;
    logic [TW-1:0]      total_reg, total_next;
    logic [3:0]         rs_flags_reg, rs_flags_next;
    logic [CW-1:0]      scan_cnt_reg, scan_cnt_next;
    logic               scan_dv_reg, scan_dv_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    rec_t               new_rec_reg;
    rec_t               rd_rec_reg;
    logic               rd_hit_reg;
    logic [SampleW-1:0] avg_reg;

    logic [SampleW-1:0] o_co2_max_reg, o_co2_min_reg, o_pk_max_reg, o_snd_min_reg;
    logic [SampleW-1:0] o_avg_reg;
    logic [CountW-1:0]  o_count_reg;
    logic               o_rv_reg;
    rec_t               o_rec_reg;

    // RAM port
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    rec_t               ram_wdata;
    logic [RecW-1:0]    ram_rdata;
    rec_t               old_rec;

    // divider
    logic               div_start;
    logic               div_done;
    logic [TW-1:0]      div_quot;

    logic [CW-1:0]      count;
    logic [XW-1:0]      count_x;
    logic               in_take;
    logic               rd_in_range;
    logic [OW:0]        rd_sum;
    logic [AW-1:0]      rd_addr;
    logic               out_free;
    logic               r1, r2, r3, r4;

    swmm_ram #(
        .WIDTH (RecW),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    swmm_div #(
        .DW (TW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (count),
        .done     (div_done),
        .quotient (div_quot)
    );

    // window fill and read address
    assign count       = wrapped_reg ? CW'(WINDOW_DEPTH) : CW'(wp_reg);
    assign count_x     = XW'(count);
    assign in_ready    = (state_reg == S_IDLE);
    assign in_take     = in_valid && in_ready;
    assign rd_in_range = OW'(read_offset) < OW'(count);
    assign old_rec     = rec_t'(ram_rdata);
    assign out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        rd_sum = (OW + 1)'(wrapped_reg ? wp_reg : AW'(0)) + (OW + 1)'(read_offset);
        if (rd_sum >= (OW + 1)'(WINDOW_DEPTH))
        begin
            rd_sum = rd_sum - (OW + 1)'(WINDOW_DEPTH);
        end
        rd_addr = rd_sum[AW-1:0];
    end

    // eviction of an extreme forces a rescan of that statistic
    assign r1 = wrapped_reg && (old_rec.co2 == co2_hi_reg);
    assign r2 = wrapped_reg && (old_rec.co2 == co2_lo_reg);
    assign r3 = wrapped_reg && (old_rec.peak == pk_hi_reg);
    assign r4 = wrapped_reg && (old_rec.snd == snd_lo_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        co2_hi_next    = co2_hi_reg;
        co2_lo_next    = co2_lo_reg;
        pk_hi_next     = pk_hi_reg;
        snd_lo_next    = snd_lo_reg;
        total_next     = total_reg;
        rs_flags_next  = rs_flags_reg;
        scan_cnt_next  = scan_cnt_reg;
        scan_dv_next   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_addr       = wp_reg;
        ram_wdata      = new_rec_reg;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (operation == OpPush)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        ram_addr   = rd_addr;
                        state_next = S_RDW;
                    end
                end
            end
            S_PUSH:
            begin
                // old record is on the read port; overwrite it
                ram_we     = 1'b1;
                total_next = total_reg + TW'(new_rec_reg.snd)
                           - (wrapped_reg ? TW'(old_rec.snd) : TW'(0));
                if (wp_reg == AW'(WINDOW_DEPTH - 1))
                begin
                    wp_next      = '0;
                    wrapped_next = 1'b1;
                end
                else
                begin
                    wp_next = wp_reg + 1'b1;
                end
                co2_hi_next = r1 ? SampleMin :
                    ((new_rec_reg.co2 > co2_hi_reg) ? new_rec_reg.co2 : co2_hi_reg);
                co2_lo_next = r2 ? SampleMax :
                    ((new_rec_reg.co2 < co2_lo_reg) ? new_rec_reg.co2 : co2_lo_reg);
                pk_hi_next  = r3 ? SampleMin :
                    ((new_rec_reg.peak > pk_hi_reg) ? new_rec_reg.peak : pk_hi_reg);
                snd_lo_next = r4 ? SampleMax :
                    ((new_rec_reg.snd < snd_lo_reg) ? new_rec_reg.snd : snd_lo_reg);
                rs_flags_next = {r4, r3, r2, r1};
                scan_cnt_next = '0;
                state_next    = (r1 || r2 || r3 || r4) ? S_SCAN : S_DIV;
            end
            S_SCAN:
            begin
                // window is full here: sweep every entry
                if (scan_cnt_reg != CW'(WINDOW_DEPTH))
                begin
                    ram_addr      = scan_cnt_reg[AW-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    scan_dv_next  = 1'b1;
                end
                if (scan_dv_reg)
                begin
                    if (rs_flags_reg[0] && old_rec.co2 > co2_hi_reg)
                    begin
                        co2_hi_next = old_rec.co2;
                    end
                    if (rs_flags_reg[1] && old_rec.co2 < co2_lo_reg)
                    begin
                        co2_lo_next = old_rec.co2;
                    end
                    if (rs_flags_reg[2] && old_rec.peak > pk_hi_reg)
                    begin
                        pk_hi_next = old_rec.peak;
                    end
                    if (rs_flags_reg[3] && old_rec.snd < snd_lo_reg)
                    begin
                        snd_lo_next = old_rec.snd;
                    end
                    if (scan_cnt_reg == CW'(WINDOW_DEPTH))
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_RDW:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (count == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            co2_hi_reg    <= SampleMin;
            co2_lo_reg    <= SampleMax;
            pk_hi_reg     <= SampleMin;
            snd_lo_reg    <= SampleMax;
            total_reg     <= '0;
            rs_flags_reg  <= '0;
            scan_cnt_reg  <= '0;
            scan_dv_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            co2_hi_reg    <= co2_hi_next;
            co2_lo_reg    <= co2_lo_next;
            pk_hi_reg     <= pk_hi_next;
            snd_lo_reg    <= snd_lo_next;
            total_reg     <= total_next;
            rs_flags_reg  <= rs_flags_next;
            scan_cnt_reg  <= scan_cnt_next;
            scan_dv_reg   <= scan_dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            new_rec_reg <= '{co2: co2_level, snd: sound_level, peak: peak_sound,
                             hr: hour_stamp, mn: minute_stamp};
            rd_hit_reg  <= (operation == OpRead) && rd_in_range;
        end
        if (state_reg == S_RDW)
        begin
            rd_rec_reg <= rd_hit_reg ? old_rec : rec_t'('0);
        end
        else if (state_reg == S_PUSH)
        begin
            rd_rec_reg <= rec_t'('0);
        end
        if (state_reg == S_DIV)
        begin
            avg_reg <= '0;
        end
        else if (div_done)
        begin
            avg_reg <= div_quot[SampleW-1:0];
        end
        if (state_reg == S_FIN && out_free)
        begin
            o_co2_max_reg <= co2_hi_reg;
            o_co2_min_reg <= co2_lo_reg;
            o_pk_max_reg  <= pk_hi_reg;
            o_snd_min_reg <= snd_lo_reg;
            o_avg_reg     <= avg_reg;
            o_count_reg   <= count_x[CountW-1:0];
            o_rv_reg      <= rd_hit_reg;
            o_rec_reg     <= rd_rec_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign co2_max        = o_co2_max_reg;
    assign co2_min        = o_co2_min_reg;
    assign peak_sound_max = o_pk_max_reg;
    assign sound_min      = o_snd_min_reg;
    assign sound_average  = o_avg_reg;
    assign record_count   = o_count_reg;
    assign rec_valid      = o_rv_reg;
    assign rec_co2        = o_rec_reg.co2;
    assign rec_sound      = o_rec_reg.snd;
    assign rec_peak       = o_rec_reg.peak;
    assign rec_hour       = o_rec_reg.hr;
    assign rec_minute     = o_rec_reg.mn;

    // a push transaction always goes to the read-modify-write step
    a_push_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && operation == OpPush) |=> state_reg == S_PUSH)
        else $error("push did not enter the write-back step");

    // a completed result is presented on the next cycle
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> (out_valid && state_reg == S_IDLE))
        else $error("finished result not presented");

    // a non-empty window at rest has ordered extremes
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && count != '0) |-> co2_lo_reg <= co2_hi_reg)
        else $error("CO2 minimum above maximum");

    // divider only finishes while it is awaited
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIVW)
        else $error("divider result outside its wait state");

    // scanning only happens on a full window
    a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> wrapped_reg)
        else $error("rescan on a window that is not full");

endmodule
